// ----- sv/scan_gap_segmenter_top_assert.svh -----
// Assertion macros for the scan gap segmenter checker.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef SCAN_GAP_SEGMENTER_TOP_ASSERT_SVH
`define SCAN_GAP_SEGMENTER_TOP_ASSERT_SVH

// Same-cycle implication.
`define SGS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SGS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sgs_pkg.sv -----
// ----------------------------------------------------------------------------
// sgs_pkg
// Shared widths, reset values, register indexes and the command and status
// structures that join the segmenter controller and datapath.
// ----------------------------------------------------------------------------
package sgs_pkg;

  localparam int RANGE_W     = 16;
  localparam int MINCNT_W    = 10;
  localparam int COUNT_W     = 10;
  localparam int CENTER_W    = 11;
  localparam int SUM_W       = 26;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int DIV_STEP_W  = $clog2(SUM_W);

  localparam int MAX_BEAMS_DEF = 1024;

  localparam logic [RANGE_W-1:0]  JUMP_THRESHOLD_RST      = RANGE_W'(500);
  localparam logic [RANGE_W-1:0]  RANGE_SUBSTITUTE_RST    = RANGE_W'(30000);
  localparam logic [RANGE_W-1:0]  MIN_SEGMENT_RANGE_RST   = RANGE_W'(2000);
  localparam logic [MINCNT_W-1:0] MIN_SEGMENT_SAMPLES_RST = MINCNT_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_JUMP_THRESHOLD      = 3'd0,
    REG_RANGE_SUBSTITUTE    = 3'd1,
    REG_MIN_SEGMENT_RANGE   = 3'd2,
    REG_MIN_SEGMENT_SAMPLES = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic div_start;
    logic div_step;
    logic out_load;
  } sgs_cmd_t;

  typedef struct packed {
    logic brk;
    logic qualifies;
    logic div_last;
    logic out_free;
  } sgs_sts_t;

endpackage

// ----- sv/sgs_if.sv -----
// ----------------------------------------------------------------------------
// sgs_if
// Valid/ready channels of the segmenter: beam samples in, segments out and
// register writes.
// ----------------------------------------------------------------------------
interface sgs_beam_if;
  import sgs_pkg::*;
  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] range_mm;
  logic               invalid;
  logic               last_in_scan;
  modport source(output valid, range_mm, invalid, last_in_scan, input ready);
  modport sink(input valid, range_mm, invalid, last_in_scan, output ready);
endinterface

interface sgs_seg_if;
  import sgs_pkg::*;
  logic                valid;
  logic                ready;
  logic [RANGE_W-1:0]  mean_range;
  logic [COUNT_W-1:0]  sample_count;
  logic [CENTER_W-1:0] center_twice;
  modport source(output valid, mean_range, sample_count, center_twice, input ready);
  modport sink(input valid, mean_range, sample_count, center_twice, output ready);
endinterface

interface sgs_cfg_if;
  import sgs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- sv/scan_gap_segmenter_top.sv -----
// Flow: each sample is accepted in S_IDLE and evaluated in S_EVAL; a segment it closes
// is tested in S_TEST, and one that qualifies is divided in S_DIV and loaded in S_FIN.
// The next sample is taken only when this sequence is through; the mean range comes
// from the 26-step restoring divider.
// A finished result waits in the output register while the next sample is taken.
// Reset: synchronous rst clears the scan state and loads the register defaults.
// ----------------------------------------------------------------------------
// scan_gap_segmenter_top
// Breakpoint segmentation of one lidar scan: closes a segment at each range
// jump and reports mean range, sample count and twice the centre index of those that qualify.
// ----------------------------------------------------------------------------
module scan_gap_segmenter_top #(
  parameter int MAX_BEAMS = sgs_pkg::MAX_BEAMS_DEF
) (
  input logic        clk,
  input logic        rst,
  sgs_beam_if.sink   beam,
  sgs_seg_if.source  segment,
  sgs_cfg_if.sink    cfg
);
  import sgs_pkg::*;

  sgs_cmd_t cmd;
  sgs_sts_t sts;

  assign cfg.ready = 1'b1;

  sgs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (beam.valid),
    .in_ready (beam.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  sgs_datapath #(
    .MAX_BEAMS (MAX_BEAMS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .in_range_mm (beam.range_mm),
    .in_invalid  (beam.invalid),
    .in_last     (beam.last_in_scan),
    .out_valid   (segment.valid),
    .out_ready   (segment.ready),
    .out_mean    (segment.mean_range),
    .out_count   (segment.sample_count),
    .out_center  (segment.center_twice)
  );

endmodule

// ----- sv/sgs_ctrl.sv -----
// ----------------------------------------------------------------------------
// sgs_ctrl
// Sequencer of the segmenter: takes one beam sample, evaluates it, tests a
// closed segment and runs the divider when the segment is to be emitted.
// ----------------------------------------------------------------------------
module sgs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output sgs_pkg::sgs_cmd_t cmd,
  input  sgs_pkg::sgs_sts_t sts
);
  import sgs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_TEST,
    S_DIV,
    S_FIN
  } state_t;

  state_t state;

  always_comb begin
    cmd           = '0;
    cmd.load      = in_valid && in_ready;
    cmd.eval      = (state == S_EVAL);
    cmd.div_start = (state == S_TEST) && sts.qualifies;
    cmd.div_step  = (state == S_DIV);
    cmd.out_load  = (state == S_FIN) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= S_EVAL;
            in_ready <= 1'b0;
          end
        end
        S_EVAL: begin
          if (sts.brk) begin
            state <= S_TEST;
          end else begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        S_TEST: begin
          if (sts.qualifies) begin
            state <= S_DIV;
          end else begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        S_DIV: begin
          if (sts.div_last) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (sts.out_free) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ----- sv/sgs_datapath.sv -----
// ----------------------------------------------------------------------------
// sgs_datapath
// Registers, scan state, segment test and the one-bit-per-cycle restoring
// divider that forms the mean range of an emitted segment.
// ----------------------------------------------------------------------------
module sgs_datapath #(
  parameter int MAX_BEAMS = sgs_pkg::MAX_BEAMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sgs_pkg::sgs_cmd_t               cmd,
  output sgs_pkg::sgs_sts_t               sts,
  input  logic                            cfg_we,
  input  logic [sgs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sgs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [sgs_pkg::RANGE_W-1:0]     in_range_mm,
  input  logic                            in_invalid,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sgs_pkg::RANGE_W-1:0]     out_mean,
  output logic [sgs_pkg::COUNT_W-1:0]     out_count,
  output logic [sgs_pkg::CENTER_W-1:0]    out_center
);
  import sgs_pkg::*;

  localparam int IDX_W  = $clog2(MAX_BEAMS);
  localparam int CW     = (IDX_W + 1 > CENTER_W) ? IDX_W + 1 : CENTER_W;
  localparam int CMW    = (IDX_W > MINCNT_W) ? IDX_W : MINCNT_W;
  localparam int CXW    = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
  localparam int PROD_W = RANGE_W + IDX_W;
  localparam int PSW    = (PROD_W > SUM_W) ? PROD_W : SUM_W;

  // Configuration registers.
  logic [RANGE_W-1:0]  jump_threshold;
  logic [RANGE_W-1:0]  range_substitute;
  logic [RANGE_W-1:0]  min_segment_range;
  logic [MINCNT_W-1:0] min_segment_samples;

  // Accepted sample.
  logic [RANGE_W-1:0] item_range;
  logic               item_last;

  // Scan state.
  logic [RANGE_W-1:0] previous_range;
  logic [SUM_W-1:0]   range_sum;
  logic [IDX_W-1:0]   segment_start;
  logic [IDX_W-1:0]   beam_index;
  logic               have_previous;

  // Snapshot of a closed segment.
  logic [IDX_W-1:0]    seg_count;
  logic [SUM_W-1:0]    seg_sum;
  logic [CENTER_W-1:0] seg_center;

  // Divider.
  logic [IDX_W-1:0]      rem;
  logic [SUM_W-1:0]      quo;
  logic [DIV_STEP_W-1:0] div_step;

  logic [RANGE_W-1:0] diff;
  logic [IDX_W-1:0]   end_index;
  logic [IDX_W-1:0]   count;
  logic [CW-1:0]      center_full;
  logic [IDX_W:0]     index_next;
  logic               scan_done;
  logic [PROD_W-1:0]  product;
  logic [IDX_W:0]     rem_shift;
  logic               rem_ge;
  logic [IDX_W:0]     rem_sub;
  logic [CXW-1:0]     count_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_threshold      <= JUMP_THRESHOLD_RST;
      range_substitute    <= RANGE_SUBSTITUTE_RST;
      min_segment_range   <= MIN_SEGMENT_RANGE_RST;
      min_segment_samples <= MIN_SEGMENT_SAMPLES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_JUMP_THRESHOLD:      jump_threshold      <= cfg_data;
        REG_RANGE_SUBSTITUTE:    range_substitute    <= cfg_data;
        REG_MIN_SEGMENT_RANGE:   min_segment_range   <= cfg_data;
        REG_MIN_SEGMENT_SAMPLES: min_segment_samples <= cfg_data[MINCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    diff = (item_range >= previous_range) ? item_range - previous_range
                                          : previous_range - item_range;
    end_index   = beam_index - IDX_W'(1);
    count       = (end_index >= segment_start) ? end_index - segment_start : '0;
    center_full = CW'(end_index) + CW'(segment_start);
    index_next  = {1'b0, beam_index} + (IDX_W + 1)'(1);
    scan_done   = item_last || (index_next >= (IDX_W + 1)'(MAX_BEAMS));
    product     = PROD_W'(min_segment_range) * PROD_W'(seg_count);
    rem_shift   = {rem, quo[SUM_W-1]};
    rem_ge      = rem_shift >= {1'b0, seg_count};
    rem_sub     = rem_shift - {1'b0, seg_count};
    count_ext   = CXW'(seg_count);
  end

  always_comb begin
    sts.brk       = have_previous && (diff >= jump_threshold);
    // The mean test is exact: sum against the minimum range times the count.
    sts.qualifies = (CMW'(seg_count) > CMW'(min_segment_samples)) &&
                    (seg_count != '0) && (PSW'(seg_sum) > PSW'(product));
    sts.div_last  = (div_step == DIV_STEP_W'(SUM_W - 1));
    sts.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_range <= in_invalid ? range_substitute : in_range_mm;
      item_last  <= in_last;
    end
    if (cmd.eval && sts.brk) begin
      seg_count  <= count;
      seg_sum    <= range_sum;
      seg_center <= center_full[CENTER_W-1:0];
    end
    if (cmd.div_start) begin
      rem      <= '0;
      quo      <= seg_sum;
      div_step <= '0;
    end else if (cmd.div_step) begin
      rem      <= rem_ge ? rem_sub[IDX_W-1:0] : rem_shift[IDX_W-1:0];
      quo      <= {quo[SUM_W-2:0], rem_ge};
      div_step <= div_step + DIV_STEP_W'(1);
    end
    if (cmd.out_load) begin
      out_mean   <= quo[RANGE_W-1:0];
      out_count  <= count_ext[COUNT_W-1:0];
      out_center <= seg_center;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_range <= '0;
      range_sum      <= '0;
      segment_start  <= '0;
      beam_index     <= '0;
      have_previous  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.eval) begin
        // A finished scan drops any open segment and starts over.
        if (scan_done) begin
          previous_range <= '0;
          range_sum      <= '0;
          segment_start  <= '0;
          beam_index     <= '0;
          have_previous  <= 1'b0;
        end else begin
          previous_range <= item_range;
          have_previous  <= 1'b1;
          beam_index     <= index_next[IDX_W-1:0];
          if (sts.brk) begin
            range_sum     <= '0;
            segment_start <= beam_index;
          end else if (have_previous) begin
            range_sum <= range_sum + SUM_W'(item_range);
          end
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/sgs_checker.sv -----
// ----------------------------------------------------------------------------
// sgs_checker
// Port-level checks of the segmenter, bound to the top level.
// ----------------------------------------------------------------------------
`include "scan_gap_segmenter_top_assert.svh"

module sgs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           beam_valid,
  input logic                           beam_ready,
  input logic                           seg_valid,
  input logic                           seg_ready,
  input logic [sgs_pkg::RANGE_W-1:0]    seg_mean,
  input logic [sgs_pkg::COUNT_W-1:0]    seg_count,
  input logic [sgs_pkg::CENTER_W-1:0]   seg_center
);
  import sgs_pkg::*;

  // A stalled segment keeps its fields.
  `SGS_ASSERT_NEXT(a_seg_hold, seg_valid && !seg_ready, seg_valid && $stable(seg_mean) && $stable(seg_count) && $stable(seg_center), "segment changed while stalled")

  // The sequencer is busy in the cycle after each sample it takes.
  `SGS_ASSERT_NEXT(a_busy_after_request, beam_valid && beam_ready, !beam_ready, "sample taken in consecutive cycles")

  // A new segment only comes out of the divider, during which no sample is taken.
  `SGS_ASSERT_IMPL(a_seg_from_divider, $rose(seg_valid), !$past(beam_ready), "segment appeared without a divide")

  // Nothing is offered in the first cycle after reset.
  `SGS_ASSERT_IMPL(a_quiet_after_reset, $past(rst), !seg_valid, "segment valid straight after reset")

endmodule

bind scan_gap_segmenter_top sgs_checker u_sgs_checker (
  .clk        (clk),
  .rst        (rst),
  .beam_valid (beam.valid),
  .beam_ready (beam.ready),
  .seg_valid  (segment.valid),
  .seg_ready  (segment.ready),
  .seg_mean   (segment.mean_range),
  .seg_count  (segment.sample_count),
  .seg_center (segment.center_twice)
);

// ----- dv/scan_gap_segmenter_top_test.sv -----
// ----------------------------------------------------------------------------
// scan_gap_segmenter_top_test
// Self-checking test of the scan gap segmenter. Beam requests from directed
// and random scans are replayed through a breakpoint predictor. Each segment
// that leaves the block is checked against the oldest predicted segment.
// ----------------------------------------------------------------------------
module scan_gap_segmenter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sgs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic               invalid;
    logic               last_in_scan;
  } beam_req_t;

  typedef struct packed {
    logic [RANGE_W-1:0]  mean_range;
    logic [COUNT_W-1:0]  sample_count;
    logic [CENTER_W-1:0] center_twice;
  } segment_t;

  typedef struct {
    logic [RANGE_W-1:0]  jump;
    logic [RANGE_W-1:0]  subst;
    logic [RANGE_W-1:0]  min_range;
    logic [MINCNT_W-1:0] min_samples;
    int                  n_items;
    int                  src_idle;
    int                  rcv_stall;
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sgs_beam_if beam();
  sgs_seg_if  segment();
  sgs_cfg_if  cfg();

  scan_gap_segmenter_top u_top (
    .clk     (clk),
    .rst     (rst),
    .beam    (beam),
    .segment (segment),
    .cfg     (cfg)
  );

  always begin
    #1ns clk = 1'b1;
    #1ns clk = 1'b0;
  end

  beam_req_t beam_backlog[$];
  segment_t  pending_segments[$];
  int        errors = 0;
  int        quiet_cycles = 0;
  int        src_idle_pct = 0;
  int        rcv_stall_pct = 0;
  logic      beam_taken;

  // Predictor copy of the thresholds and of the scan state.
  logic [RANGE_W-1:0]  thr_jump;
  logic [RANGE_W-1:0]  thr_subst;
  logic [RANGE_W-1:0]  thr_min_range;
  logic [MINCNT_W-1:0] thr_min_samples;
  logic [RANGE_W-1:0]  prev_range;
  logic [SUM_W-1:0]    run_sum;
  int unsigned         seg_start;
  int unsigned         beam_idx;
  bit                  have_prev;

  function automatic void restart_scan();
    prev_range = '0;
    run_sum    = '0;
    seg_start  = 0;
    beam_idx   = 0;
    have_prev  = 1'b0;
  endfunction

  // Advances the scan by one beam; returns 1 when a segment closes and qualifies.
  function automatic bit breakpoint_step(input beam_req_t req, output segment_t seg);
    logic [RANGE_W-1:0] r;
    logic [RANGE_W-1:0] diff;
    int unsigned        last_idx;
    int unsigned        count;
    bit                 emit;
    emit = 1'b0;
    seg  = '0;
    r = req.invalid ? thr_subst : req.range_mm;
    if (have_prev) begin
      diff = (r >= prev_range) ? r - prev_range : prev_range - r;
      if (diff < thr_jump) begin
        run_sum = run_sum + SUM_W'(r);
      end else begin
        last_idx = beam_idx - 1;
        count = (last_idx >= seg_start) ? last_idx - seg_start : 0;
        // The mean test is made on the exact sum, not on the truncated mean.
        if (count > thr_min_samples && count > 0 &&
            64'(run_sum) > 64'(thr_min_range) * 64'(count)) begin
          seg.mean_range   = RANGE_W'(run_sum / count);
          seg.sample_count = COUNT_W'(count);
          seg.center_twice = CENTER_W'(last_idx + seg_start);
          emit = 1'b1;
        end
        run_sum   = '0;
        seg_start = beam_idx;
      end
    end
    prev_range = r;
    have_prev  = 1'b1;
    beam_idx++;
    if (req.last_in_scan || beam_idx >= MAX_BEAMS_DEF) restart_scan();
    return emit;
  endfunction

  task automatic report(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t ns: %s", $realtime, msg);
  endtask

  // Sample side: predictor, checker and watchdog.
  always @(posedge clk) begin
    beam_req_t seen;
    segment_t  got;
    segment_t  want;
    if (rst) begin
      beam_taken      <= 1'b0;
      thr_jump        = JUMP_THRESHOLD_RST;
      thr_subst       = RANGE_SUBSTITUTE_RST;
      thr_min_range   = MIN_SEGMENT_RANGE_RST;
      thr_min_samples = MIN_SEGMENT_SAMPLES_RST;
      restart_scan();
    end else begin
      beam_taken <= beam.valid && beam.ready;
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_JUMP_THRESHOLD:      thr_jump        = cfg.data;
          REG_RANGE_SUBSTITUTE:    thr_subst       = cfg.data;
          REG_MIN_SEGMENT_RANGE:   thr_min_range   = cfg.data;
          REG_MIN_SEGMENT_SAMPLES: thr_min_samples = cfg.data[MINCNT_W-1:0];
          default: ;
        endcase
      end
      if (beam.valid && beam.ready) begin
        seen = {beam.range_mm, beam.invalid, beam.last_in_scan};
        if (breakpoint_step(seen, got)) pending_segments = {pending_segments, got};
      end
      if (segment.valid && segment.ready) begin
        if (pending_segments.size() == 0) begin
          report($sformatf("unexpected segment: mean %0d count %0d centre2 %0d",
                           segment.mean_range, segment.sample_count,
                           segment.center_twice));
        end else begin
          want = pending_segments.pop_front();
          if (segment.mean_range !== want.mean_range ||
              segment.sample_count !== want.sample_count ||
              segment.center_twice !== want.center_twice) begin
            report($sformatf({"segment mismatch (expected/actual): mean %0d/%0d ",
                              "count %0d/%0d centre2 %0d/%0d"},
                             want.mean_range, segment.mean_range,
                             want.sample_count, segment.sample_count,
                             want.center_twice, segment.center_twice));
          end
        end
      end
      if ((beam.valid && beam.ready) || (segment.valid && segment.ready) ||
          (cfg.valid && cfg.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("scan_gap_segmenter_top_test: done, errors");
        $finish;
      end
    end
  end

  // Beam driver: takes the next request from the backlog once the last one is gone.
  always @(negedge clk) begin
    beam_req_t req;
    if (rst) begin
      beam.valid <= 1'b0;
    end else if (beam_taken || !beam.valid) begin
      if (beam_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        req = beam_backlog.pop_front();
        beam.valid        <= 1'b1;
        beam.range_mm     <= req.range_mm;
        beam.invalid      <= req.invalid;
        beam.last_in_scan <= req.last_in_scan;
      end else begin
        beam.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      segment.ready <= 1'b0;
    end else begin
      segment.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic program_thresholds(input logic [RANGE_W-1:0] jump,
                                    input logic [RANGE_W-1:0] subst,
                                    input logic [RANGE_W-1:0] min_range,
                                    input logic [MINCNT_W-1:0] min_samples);
    write_reg(REG_JUMP_THRESHOLD, jump);
    write_reg(REG_RANGE_SUBSTITUTE, subst);
    write_reg(REG_MIN_SEGMENT_RANGE, min_range);
    write_reg(REG_MIN_SEGMENT_SAMPLES, CFG_DATA_W'(min_samples));
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Holds the sender until every predicted segment is out, then lets a
  // closed but unqualified segment finish inside the block as well.
  task automatic settle();
    do @(negedge clk);
    while (beam_backlog.size() != 0 || beam.valid || pending_segments.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Scans built from flat stretches with small steps, broken by jumps,
  // with a sprinkling of invalid readings and random noise.
  task automatic queue_scans(input int n_items, input int seg_max,
                             input int len_lo, input int len_hi);
    int                 left;
    int                 scan_len;
    int                 seg_left;
    int                 step_max;
    int                 delta;
    int                 v;
    int                 pick;
    logic [RANGE_W-1:0] level;
    beam_req_t          req;
    left     = n_items;
    seg_left = 0;
    level    = '0;
    step_max = (thr_jump > 1) ? int'(thr_jump) - 1 : 0;
    if (step_max > 1500) step_max = 1500;
    while (left > 0) begin
      scan_len = $urandom_range(len_hi, len_lo);
      if (scan_len > left) scan_len = left;
      for (int k = 0; k < scan_len; k++) begin
        if (seg_left == 0) begin
          case ($urandom_range(7))
            0:       level = '0;
            1:       level = '1;
            default: level = RANGE_W'($urandom);
          endcase
          seg_left = $urandom_range(seg_max, 1);
        end
        seg_left--;
        pick = $urandom_range(99);
        if (pick < 6) begin
          req.range_mm = RANGE_W'($urandom);
          req.invalid  = 1'($urandom_range(1));
        end else if (pick < 10) begin
          req.range_mm = RANGE_W'($urandom);
          req.invalid  = 1'b1;
        end else begin
          delta = $urandom_range(step_max, 0);
          v = $urandom_range(1) ? int'(level) + delta : int'(level) - delta;
          if (v < 0) v = 0;
          else if (v > 65535) v = 65535;
          level        = RANGE_W'(v);
          req.range_mm = level;
          req.invalid  = 1'b0;
        end
        req.last_in_scan = (k == scan_len - 1);
        beam_backlog = {beam_backlog, req};
      end
      left -= scan_len;
    end
  endtask

  initial begin
    beam_req_t directed[$] = '{
      // Flat run whose sum only equals the range floor times the count.
      {16'd1000, 1'b0, 1'b0}, {16'd1000, 1'b0, 1'b0},
      {16'd1000, 1'b0, 1'b0}, {16'd1000, 1'b0, 1'b0},
      {16'd65535, 1'b0, 1'b0}, {16'd65535, 1'b0, 1'b0},
      {16'd65400, 1'b0, 1'b0}, {16'd65300, 1'b0, 1'b0},
      // Invalid readings take the substitute, whatever the range field says.
      {16'd12345, 1'b1, 1'b0}, {16'd0, 1'b1, 1'b0},
      {16'd1000, 1'b0, 1'b0}, {16'd1000, 1'b0, 1'b0},
      {16'd1000, 1'b0, 1'b0}, {16'd1001, 1'b0, 1'b0},
      {16'd0, 1'b0, 1'b0}, {16'd0, 1'b0, 1'b1},
      // An open segment at the end of a scan is dropped.
      {16'd5000, 1'b0, 1'b0}, {16'd5000, 1'b0, 1'b0},
      {16'd5100, 1'b0, 1'b0}, {16'd5200, 1'b0, 1'b0},
      {16'd5300, 1'b0, 1'b1},
      // Back-to-back jumps leave segments with nothing summed.
      {16'd40000, 1'b0, 1'b0}, {16'd0, 1'b0, 1'b0},
      {16'd65535, 1'b0, 1'b0}, {16'd65535, 1'b0, 1'b0},
      {16'd65535, 1'b0, 1'b0}, {16'd65535, 1'b0, 1'b1}
    };
    phase_t plan [7] = '{
      '{16'd500,   16'd30000, 16'd2000,  10'd3,    24, 0,  0},
      '{16'd2000,  16'd0,     16'd0,     10'd0,    24, 71, 0},
      '{16'd40000, 16'd65535, 16'd100,   10'd1,    24, 0,  71},
      '{16'd0,     16'd1234,  16'd0,     10'd0,    24, 16, 16},
      '{16'd65535, 16'd20000, 16'd65535, 10'd0,    24, 0,  0},
      '{16'd800,   16'd65535, 16'd500,   10'd1023, 24, 71, 0},
      '{16'd1000,  16'd100,   16'd1500,  10'd5,    24, 16, 16}
    };

    beam.valid        = 1'b0;
    beam.range_mm     = '0;
    beam.invalid      = 1'b0;
    beam.last_in_scan = 1'b0;
    segment.ready     = 1'b0;
    cfg.valid         = 1'b0;
    cfg.index         = REG_JUMP_THRESHOLD;
    cfg.data          = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    program_thresholds(16'd500, 16'd3000, 16'd1000, 10'd2);
    foreach (directed[i]) beam_backlog = {beam_backlog, directed[i]};
    settle();

    foreach (plan[p]) begin
      program_thresholds(plan[p].jump, plan[p].subst, plan[p].min_range,
                         plan[p].min_samples);
      src_idle_pct  = plan[p].src_idle;
      rcv_stall_pct = plan[p].rcv_stall;
      // The phase is split so that the sender pauses for the results midway.
      queue_scans(plan[p].n_items / 2, 20, 1, 120);
      settle();
      queue_scans(plan[p].n_items - plan[p].n_items / 2, 20, 1, 120);
      settle();
    end

    // One scan that runs past the beam limit without an end flag in time.
    program_thresholds(16'd200, 16'd20000, 16'd0, 10'd3);
    src_idle_pct  = 0;
    rcv_stall_pct = 71;
    queue_scans(MAX_BEAMS_DEF + 6, 40, MAX_BEAMS_DEF + 6, MAX_BEAMS_DEF + 6);
    settle();

    errors += pending_segments.size();
    if (errors == 0) begin
      $display("scan_gap_segmenter_top_test: done, clean");
    end else begin
      $display("scan_gap_segmenter_top_test: done, errors");
    end
    $finish;
  end

endmodule
